### hdl/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define AVT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("avt assertion failed");

// check on every clock edge, reset included
`define AVT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("avt assertion failed");

`endif

### hdl/avt_pkg.sv
// shared constants and types of the affine vertex transform
// no dependencies
package avt_pkg;

    localparam int VALUE_WIDTH_DEFAULT   = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int OP_WIDTH       = 2;
    localparam int INDEX_WIDTH    = 4;
    localparam int MATRIX_ROWS    = 3;
    localparam int MATRIX_COLS    = 4;
    localparam int MATRIX_ENTRIES = MATRIX_ROWS * MATRIX_COLS;
    localparam int VECTOR_LEN     = 3;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD      = 2'd0,
        OP_POINT     = 2'd1,
        OP_DIRECTION = 2'd2,
        OP_RESERVED  = 2'd3
    } op_t;

    // control part of a queued command, the words travel beside it
    typedef struct packed {
        op_t                    op;
        logic [INDEX_WIDTH-1:0] index;
        logic                   last;
    } cmd_t;

endpackage

### hdl/avt_front.sv
// front end: input handshake, command classification and input register
// depends on avt_pkg
module avt_front #(
    parameter int VALUE_WIDTH = avt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [avt_pkg::OP_WIDTH-1:0]            s_operation,
    input  logic [avt_pkg::INDEX_WIDTH-1:0]         s_entry_index,
    input  logic signed [VALUE_WIDTH-1:0]           s_entry_value,
    input  logic signed [VALUE_WIDTH-1:0]           s_x_in,
    input  logic signed [VALUE_WIDTH-1:0]           s_y_in,
    input  logic signed [VALUE_WIDTH-1:0]           s_z_in,
    input  logic                                    s_last_in,
    output logic                                    q_valid,
    input  logic                                    q_ready,
    output avt_pkg::cmd_t                           q_cmd,
    output logic [avt_pkg::VECTOR_LEN*VALUE_WIDTH-1:0] q_data
);

    localparam int DATA_W = avt_pkg::VECTOR_LEN * VALUE_WIDTH;

    logic              cmd_valid_reg, cmd_valid_next;
    avt_pkg::cmd_t     cmd_reg, cmd_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              keep;
    logic              accept;

    // drop reserved codes and loads past the last entry
    always_comb begin
        case (avt_pkg::op_t'(s_operation))
            avt_pkg::OP_LOAD: begin
                keep = s_entry_index < avt_pkg::INDEX_WIDTH'(avt_pkg::MATRIX_ENTRIES);
            end
            avt_pkg::OP_POINT, avt_pkg::OP_DIRECTION: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = !cmd_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd_next.op    = avt_pkg::op_t'(s_operation);
        cmd_next.index = s_entry_index;
        cmd_next.last  = s_last_in;
        // a load carries its value in the x slot
        if (avt_pkg::op_t'(s_operation) == avt_pkg::OP_LOAD) begin
            data_next = {s_z_in, s_y_in, s_entry_value};
        end else begin
            data_next = {s_z_in, s_y_in, s_x_in};
        end
        if (accept) begin
            cmd_valid_next = keep;
        end else if (q_ready) begin
            cmd_valid_next = 1'b0;
        end else begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            cmd_reg  <= cmd_next;
            data_reg <= data_next;
        end
    end

    assign q_valid = cmd_valid_reg;
    assign q_cmd   = cmd_reg;
    assign q_data  = data_reg;

endmodule

### hdl/avt_fifo.sv
// small command queue between front and back end
// no package dependencies
module avt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != COUNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hdl/avt_back.sv
// back end: matrix store, multiply pipeline, row sums, saturation, output register
// depends on avt_pkg
module avt_back #(
    parameter int VALUE_WIDTH   = avt_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = avt_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       q_valid,
    output logic                                       q_ready,
    input  avt_pkg::cmd_t                              q_cmd,
    input  logic [avt_pkg::VECTOR_LEN*VALUE_WIDTH-1:0] q_data,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [VALUE_WIDTH-1:0]              m_x_out,
    output logic signed [VALUE_WIDTH-1:0]              m_y_out,
    output logic signed [VALUE_WIDTH-1:0]              m_z_out,
    output logic                                       m_saturated,
    output logic                                       m_last_out
);

    localparam int W       = VALUE_WIDTH;
    localparam int ROWS    = avt_pkg::MATRIX_ROWS;
    localparam int COLS    = avt_pkg::MATRIX_COLS;
    localparam int VLEN    = avt_pkg::VECTOR_LEN;
    localparam int LO_W    = W / 2;
    localparam int HI_W    = W - LO_W;
    localparam int PP_LO_W = W + LO_W + 1;
    localparam int PP_HI_W = W + HI_W;
    localparam int PROD_W  = 2 * W;
    localparam int SHIFT_W = PROD_W - FRACTION_BITS;
    localparam int SUM_W   = SHIFT_W + 2;

    localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_WORD = ~MAX_WORD;
    localparam logic [W-1:0] ONE_WORD = (FRACTION_BITS >= W - 1) ? MAX_WORD
                                                                 : (W'(1) << FRACTION_BITS);

    logic advance;
    logic pop;

    // matrix store
    logic signed [W-1:0] mat_reg  [avt_pkg::MATRIX_ENTRIES];
    logic signed [W-1:0] mat_next [avt_pkg::MATRIX_ENTRIES];

    // stage 1: partial products
    logic                      s1_valid_reg;
    logic signed [PP_LO_W-1:0] pp_lo_reg  [ROWS][VLEN];
    logic signed [PP_LO_W-1:0] pp_lo_next [ROWS][VLEN];
    logic signed [PP_HI_W-1:0] pp_hi_reg  [ROWS][VLEN];
    logic signed [PP_HI_W-1:0] pp_hi_next [ROWS][VLEN];
    logic signed [W-1:0]       s1_trans_reg [ROWS];
    logic                      s1_point_reg;
    logic                      s1_last_reg;

    // stage 2: full products shifted down
    logic                      s2_valid_reg;
    logic signed [SHIFT_W-1:0] shp_reg  [ROWS][VLEN];
    logic signed [SHIFT_W-1:0] shp_next [ROWS][VLEN];
    logic signed [W-1:0]       s2_trans_reg [ROWS];
    logic                      s2_point_reg;
    logic                      s2_last_reg;

    // stage 3: row sums
    logic                    s3_valid_reg;
    logic signed [SUM_W-1:0] sum_reg  [ROWS];
    logic signed [SUM_W-1:0] sum_next [ROWS];
    logic                    s3_last_reg;

    // output register
    logic                m_valid_reg;
    logic signed [W-1:0] out_reg  [ROWS];
    logic signed [W-1:0] out_next [ROWS];
    logic                sat_reg, sat_next;
    logic                last_reg;

    logic signed [W-1:0] vec [VLEN];

    assign advance = !m_valid_reg || m_ready;
    assign q_ready = advance;
    assign pop     = q_valid && advance;

    always_comb begin
        for (int c = 0; c < VLEN; c++) begin
            vec[c] = q_data[c*W +: W];
        end
    end

    // loads update the store in queue order
    always_comb begin
        for (int i = 0; i < avt_pkg::MATRIX_ENTRIES; i++) begin
            mat_next[i] = mat_reg[i];
        end
        if (pop && q_cmd.op == avt_pkg::OP_LOAD) begin
            mat_next[q_cmd.index] = vec[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < avt_pkg::MATRIX_ENTRIES; i++) begin
                mat_reg[i] <= (i % (COLS + 1) == 0) ? ONE_WORD : '0;
            end
        end else begin
            for (int i = 0; i < avt_pkg::MATRIX_ENTRIES; i++) begin
                mat_reg[i] <= mat_next[i];
            end
        end
    end

    // split each component into an unsigned low half and a signed high half
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < VLEN; c++) begin
                pp_lo_next[r][c] = mat_reg[r*COLS + c] * $signed({1'b0, vec[c][LO_W-1:0]});
                pp_hi_next[r][c] = mat_reg[r*COLS + c] * $signed(vec[c][W-1:LO_W]);
            end
        end
    end

    // recombine and floor-shift by the fraction bits
    always_comb begin
        logic signed [PROD_W-1:0] prod;
        prod = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < VLEN; c++) begin
                prod = (PROD_W'(pp_hi_reg[r][c]) <<< LO_W) + PROD_W'(pp_lo_reg[r][c]);
                shp_next[r][c] = SHIFT_W'(prod >>> FRACTION_BITS);
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] trans_term;
        trans_term = '0;
        for (int r = 0; r < ROWS; r++) begin
            trans_term = s2_point_reg ? SUM_W'(s2_trans_reg[r]) : '0;
            sum_next[r] = SUM_W'(shp_reg[r][0]) + SUM_W'(shp_reg[r][1])
                        + SUM_W'(shp_reg[r][2]) + trans_term;
        end
    end

    // clamp when the bits above the word are not a sign extension
    always_comb begin
        logic [SUM_W-W:0] upper;
        upper    = '0;
        sat_next = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            upper = sum_reg[r][SUM_W-1:W-1];
            if (&upper || ~|upper) begin
                out_next[r] = sum_reg[r][W-1:0];
            end else begin
                out_next[r] = sum_reg[r][SUM_W-1] ? MIN_WORD : MAX_WORD;
                sat_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop && q_cmd.op != avt_pkg::OP_LOAD;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pp_lo_reg    <= pp_lo_next;
            pp_hi_reg    <= pp_hi_next;
            for (int r = 0; r < ROWS; r++) begin
                s1_trans_reg[r] <= mat_reg[r*COLS + COLS - 1];
            end
            s1_point_reg <= q_cmd.op == avt_pkg::OP_POINT;
            s1_last_reg  <= q_cmd.last;

            shp_reg      <= shp_next;
            s2_trans_reg <= s1_trans_reg;
            s2_point_reg <= s1_point_reg;
            s2_last_reg  <= s1_last_reg;

            sum_reg      <= sum_next;
            s3_last_reg  <= s2_last_reg;

            out_reg      <= out_next;
            sat_reg      <= sat_next;
            last_reg     <= s3_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_x_out     = out_reg[0];
    assign m_y_out     = out_reg[1];
    assign m_z_out     = out_reg[2];
    assign m_saturated = sat_reg;
    assign m_last_out  = last_reg;

endmodule

### hdl/affine_vertex_transform_core.sv
// top level of the affine 3x4 vertex transform core
// depends on avt_pkg, avt_front, avt_fifo, avt_back
//
// usage
//   input channel s_*: one word per cycle while s_ready is high. operation
//   selects load of one matrix entry (entry_index = row*4 + column, value in
//   entry_value), transform of a point (adds the translation column) or
//   transform of a direction (no translation). reserved operation codes and
//   loads past entry 11 are swallowed without a result
//   result channel m_*: one word per transformed vertex with x/y/z in the
//   same fixed-point format, a saturated flag and the copied last marker;
//   loads never give a result
//   throughput: one word per cycle in both directions while m_ready is high,
//   set by the fully pipelined back end (one multiply stage, one recombine
//   stage, one sum stage and the output register)
//   path to m_valid: front register, queue, back-end stages, output register
//   reset: matrix returns to identity with zero translation, all queues and
//   pipeline stages empty, s_ready high once reset has cleared the front register
//   stall: a low m_ready while m_valid is high holds the output word and freezes
//   the back end; the 4-entry queue and the front register keep taking words until full
module affine_vertex_transform_core #(
    parameter int VALUE_WIDTH   = avt_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = avt_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [avt_pkg::OP_WIDTH-1:0]    s_operation,
    input  logic [avt_pkg::INDEX_WIDTH-1:0] s_entry_index,
    input  logic signed [VALUE_WIDTH-1:0]   s_entry_value,
    input  logic signed [VALUE_WIDTH-1:0]   s_x_in,
    input  logic signed [VALUE_WIDTH-1:0]   s_y_in,
    input  logic signed [VALUE_WIDTH-1:0]   s_z_in,
    input  logic                            s_last_in,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [VALUE_WIDTH-1:0]   m_x_out,
    output logic signed [VALUE_WIDTH-1:0]   m_y_out,
    output logic signed [VALUE_WIDTH-1:0]   m_z_out,
    output logic                            m_saturated,
    output logic                            m_last_out
);

    // queue word: command control bits on top, three value slots below
    localparam int DATA_W = avt_pkg::VECTOR_LEN * VALUE_WIDTH;
    localparam int CMD_W  = $bits(avt_pkg::cmd_t);
    localparam int QW     = CMD_W + DATA_W;

    logic              front_valid;
    logic              front_ready;
    avt_pkg::cmd_t     front_cmd;
    logic [DATA_W-1:0] front_data;

    logic              back_valid;
    logic              back_ready;
    logic [QW-1:0]     back_word;
    avt_pkg::cmd_t     back_cmd;
    logic [DATA_W-1:0] back_data;

    // front end classifies and registers accepted words
    avt_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_x_in        (s_x_in),
        .s_y_in        (s_y_in),
        .s_z_in        (s_z_in),
        .s_last_in     (s_last_in),
        .q_valid       (front_valid),
        .q_ready       (front_ready),
        .q_cmd         (front_cmd),
        .q_data        (front_data)
    );

    // decoupling queue, lets the front keep accepting while the back stalls
    avt_fifo #(
        .WIDTH (QW),
        .DEPTH (avt_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   ({front_cmd, front_data}),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_word)
    );

    assign back_cmd  = back_word[QW-1 -: CMD_W];
    assign back_data = back_word[DATA_W-1:0];

    // back end applies loads and runs the transform pipeline
    avt_back #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (back_valid),
        .q_ready     (back_ready),
        .q_cmd       (back_cmd),
        .q_data      (back_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_x_out     (m_x_out),
        .m_y_out     (m_y_out),
        .m_z_out     (m_z_out),
        .m_saturated (m_saturated),
        .m_last_out  (m_last_out)
    );

endmodule

### hdl/avt_checker.sv
// port-level checker for the vertex transform core, bound to the top level
// depends on assert_macros.svh and avt_pkg
`include "assert_macros.svh"

module avt_checker #(
    parameter int VALUE_WIDTH = avt_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [VALUE_WIDTH-1:0] m_x_out,
    input logic signed [VALUE_WIDTH-1:0] m_y_out,
    input logic signed [VALUE_WIDTH-1:0] m_z_out,
    input logic                          m_saturated,
    input logic                          m_last_out
);

    localparam logic [VALUE_WIDTH-1:0] MAX_WORD = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_WORD = ~MAX_WORD;

    logic [3*VALUE_WIDTH+1:0] out_word;
    logic                     at_limit;

    // whole result word and any component sitting at a range limit
    assign out_word = {m_x_out, m_y_out, m_z_out, m_saturated, m_last_out};
    assign at_limit = m_x_out == MAX_WORD || m_x_out == MIN_WORD
                   || m_y_out == MAX_WORD || m_y_out == MIN_WORD
                   || m_z_out == MAX_WORD || m_z_out == MIN_WORD;

    // reset leaves no result pending and the input side open
    `AVT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready)

    // a stalled result is not withdrawn
    `AVT_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid)

    // a stalled result keeps its word
    `AVT_ASSERT(a_hold_word, aclk, aresetn, m_valid && !m_ready |=> $stable(out_word))

    // a flagged result has at least one component at a range limit
    `AVT_ASSERT(a_sat_limit, aclk, aresetn, m_valid && m_saturated |-> at_limit)

endmodule

bind affine_vertex_transform_core avt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_avt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_x_out     (m_x_out),
    .m_y_out     (m_y_out),
    .m_z_out     (m_z_out),
    .m_saturated (m_saturated),
    .m_last_out  (m_last_out)
);

### tb/avt_transform_checker.sv
// result checker for the affine vertex transform core: tracks the matrix from
// accepted load words, predicts every transformed vertex and compares results
// depends on avt_pkg
module avt_transform_checker #(
    parameter int VALUE_WIDTH   = avt_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = avt_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [avt_pkg::OP_WIDTH-1:0]    s_operation,
    input  logic [avt_pkg::INDEX_WIDTH-1:0] s_entry_index,
    input  logic signed [VALUE_WIDTH-1:0]   s_entry_value,
    input  logic signed [VALUE_WIDTH-1:0]   s_x_in,
    input  logic signed [VALUE_WIDTH-1:0]   s_y_in,
    input  logic signed [VALUE_WIDTH-1:0]   s_z_in,
    input  logic                            s_last_in,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [VALUE_WIDTH-1:0]   m_x_out,
    input  logic signed [VALUE_WIDTH-1:0]   m_y_out,
    input  logic signed [VALUE_WIDTH-1:0]   m_z_out,
    input  logic                            m_saturated,
    input  logic                            m_last_out,
    output int                              error_count,
    output int                              expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    import avt_pkg::*;

    // sums are kept wide enough that nothing wraps before the clamp
    localparam int SUM_WIDTH = 2 * VALUE_WIDTH + 2;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX =
        (SUM_WIDTH'(1) << (VALUE_WIDTH - 1)) - SUM_WIDTH'(1);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = -SUM_MAX - 1;
    localparam logic signed [VALUE_WIDTH-1:0] WORD_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    // one in fixed point, clamped when the format cannot hold it
    localparam logic signed [VALUE_WIDTH-1:0] UNIT =
        (FRACTION_BITS >= VALUE_WIDTH - 1) ? WORD_MAX : (VALUE_WIDTH'(1) << FRACTION_BITS);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] x;
        logic signed [VALUE_WIDTH-1:0] y;
        logic signed [VALUE_WIDTH-1:0] z;
        logic                          clamped;
        logic                          last;
    } vertex_word_t;

    logic signed [VALUE_WIDTH-1:0] matrix_q [MATRIX_ENTRIES];
    vertex_word_t                  expected_vertices [$];
    vertex_word_t                  next_vertex;

    initial begin
        error_count   = 0;
        expected_left = 0;
    end

    // exact product, then floor shift
    function automatic logic signed [SUM_WIDTH-1:0] scaled_product(
        input logic signed [VALUE_WIDTH-1:0] coef,
        input logic signed [VALUE_WIDTH-1:0] comp
    );
        logic signed [SUM_WIDTH-1:0] wide_coef;
        logic signed [SUM_WIDTH-1:0] wide_comp;
        wide_coef = coef;
        wide_comp = comp;
        return (wide_coef * wide_comp) >>> FRACTION_BITS;
    endfunction

    function automatic vertex_word_t transform_vertex(
        input op_t                           op,
        input logic signed [VALUE_WIDTH-1:0] vx,
        input logic signed [VALUE_WIDTH-1:0] vy,
        input logic signed [VALUE_WIDTH-1:0] vz,
        input logic                          last
    );
        vertex_word_t                  res;
        logic signed [SUM_WIDTH-1:0]   sum;
        logic signed [VALUE_WIDTH-1:0] comp [VECTOR_LEN];
        logic                          clamped;
        clamped = 1'b0;
        for (int row = 0; row < MATRIX_ROWS; row++) begin
            sum = scaled_product(matrix_q[row*MATRIX_COLS], vx)
                + scaled_product(matrix_q[row*MATRIX_COLS+1], vy)
                + scaled_product(matrix_q[row*MATRIX_COLS+2], vz);
            if (op == OP_POINT) begin
                sum = sum + matrix_q[row*MATRIX_COLS+3];
            end
            if (sum > SUM_MAX) begin
                comp[row] = WORD_MAX;
                clamped   = 1'b1;
            end else if (sum < SUM_MIN) begin
                comp[row] = SUM_MIN[VALUE_WIDTH-1:0];
                clamped   = 1'b1;
            end else begin
                comp[row] = sum[VALUE_WIDTH-1:0];
            end
        end
        res.x       = comp[0];
        res.y       = comp[1];
        res.z       = comp[2];
        res.clamped = clamped;
        res.last    = last;
        return res;
    endfunction

    task automatic compare_field(
        input string                         what,
        input logic signed [VALUE_WIDTH-1:0] want,
        input logic signed [VALUE_WIDTH-1:0] got
    );
        if (got !== want) begin
            $display("%0t avt checker: %s expected %0d actual %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            // identity with zero translation
            for (int i = 0; i < MATRIX_ENTRIES; i++) begin
                matrix_q[i] = (i % MATRIX_COLS == i / MATRIX_COLS) ? UNIT : '0;
            end
            expected_vertices.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t avt checker: result word with nothing expected, %s",
                             $time, "see actual below");
                    $display("%0t avt checker: actual x %0d y %0d z %0d",
                             $time, m_x_out, m_y_out, m_z_out);
                    error_count++;
                end else begin
                    next_vertex = expected_vertices.pop_front();
                    compare_field("x_out", next_vertex.x, m_x_out);
                    compare_field("y_out", next_vertex.y, m_y_out);
                    compare_field("z_out", next_vertex.z, m_z_out);
                    compare_field("saturated", VALUE_WIDTH'(next_vertex.clamped),
                                  VALUE_WIDTH'(m_saturated));
                    compare_field("last_out", VALUE_WIDTH'(next_vertex.last),
                                  VALUE_WIDTH'(m_last_out));
                end
            end
            if (s_valid && s_ready) begin
                case (op_t'(s_operation))
                    OP_LOAD: begin
                        // loads past the last entry are dropped
                        if (s_entry_index < MATRIX_ENTRIES) begin
                            matrix_q[s_entry_index] = s_entry_value;
                        end
                    end
                    OP_POINT, OP_DIRECTION: begin
                        expected_vertices.push_back(transform_vertex(op_t'(s_operation),
                            s_x_in, s_y_in, s_z_in, s_last_in));
                    end
                    default: begin
                    end
                endcase
            end
        end
        expected_left <= expected_vertices.size();
    end

endmodule

### tb/affine_vertex_transform_core_test.sv
// top of the affine vertex transform core testbench: clock, reset, stimulus
// and verdict; prediction and comparison live in avt_transform_checker
// depends on avt_pkg, avt_transform_checker and the core rtl
module affine_vertex_transform_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import avt_pkg::*;

    localparam int VW = VALUE_WIDTH_DEFAULT;
    localparam int FB = FRACTION_BITS_DEFAULT;

    // handy data words in fixed point
    localparam logic [VW-1:0] WORD_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] WORD_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] UNIT_WORD = VW'(1) << FB;
    // +-16.0, keeps most sums clear of the clamp
    localparam int SMALL_SPAN = 1 << 20;

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_START  = 300;
    localparam int QUIET_END    = 500;
    localparam int DRAIN_AT     = 650;
    // give stray words time to show up after the last expected vertex
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_NS  = 5_000_000;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [OP_WIDTH-1:0]    s_operation   = OP_LOAD;
    logic [INDEX_WIDTH-1:0] s_entry_index = '0;
    logic [VW-1:0]          s_entry_value = '0;
    logic [VW-1:0]          s_x_in        = '0;
    logic [VW-1:0]          s_y_in        = '0;
    logic [VW-1:0]          s_z_in        = '0;
    logic                   s_last_in     = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [VW-1:0]          m_x_out;
    logic [VW-1:0]          m_y_out;
    logic [VW-1:0]          m_z_out;
    logic                   m_saturated;
    logic                   m_last_out;

    int error_count;
    int expected_left;
    // idle odds in percent for the sender and the receiver
    int busy_pct  = 25;
    int stall_pct = 25;

    always #6 aclk = ~aclk;

    affine_vertex_transform_core #(
        .VALUE_WIDTH  (VW),
        .FRACTION_BITS(FB)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_entry_index(s_entry_index),
        .s_entry_value(s_entry_value),
        .s_x_in       (s_x_in),
        .s_y_in       (s_y_in),
        .s_z_in       (s_z_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_out      (m_x_out),
        .m_y_out      (m_y_out),
        .m_z_out      (m_z_out),
        .m_saturated  (m_saturated),
        .m_last_out   (m_last_out)
    );

    avt_transform_checker #(
        .VALUE_WIDTH  (VW),
        .FRACTION_BITS(FB)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_entry_index(s_entry_index),
        .s_entry_value(s_entry_value),
        .s_x_in       (s_x_in),
        .s_y_in       (s_y_in),
        .s_z_in       (s_z_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_out      (m_x_out),
        .m_y_out      (m_y_out),
        .m_z_out      (m_z_out),
        .m_saturated  (m_saturated),
        .m_last_out   (m_last_out),
        .error_count  (error_count),
        .expected_left(expected_left)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // mostly small values, some full-range noise and some corner words
    function automatic logic [VW-1:0] pick_value();
        int          span_pick;
        int          small_val;
        logic [63:0] raw;
        span_pick = $urandom_range(0, 99);
        small_val = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
        raw       = {$urandom, $urandom};
        if (span_pick < 20) begin
            return raw[VW-1:0];
        end
        if (span_pick < 80) begin
            return VW'(small_val);
        end
        case ($urandom_range(0, 4))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return UNIT_WORD;
        endcase
    endfunction

    // present one word and hold it until the core takes it; random idle
    // cycles go in front, valid stays high across back-to-back words
    task automatic send_word(
        input op_t                    op,
        input logic [INDEX_WIDTH-1:0] idx,
        input logic [VW-1:0]          value,
        input logic [VW-1:0]          vx,
        input logic [VW-1:0]          vy,
        input logic [VW-1:0]          vz,
        input logic                   last
    );
        while ($urandom_range(0, 99) < busy_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_entry_index <= idx;
        s_entry_value <= value;
        s_x_in        <= vx;
        s_y_in        <= vy;
        s_z_in        <= vz;
        s_last_in     <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // watchdog, far above the slowest legal run
    initial begin
        #(WATCHDOG_NS);
        $display("affine_vertex_transform_core_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        int                     effective;
        int                     choice;
        logic [INDEX_WIDTH-1:0] idx;
        bit                     drained;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // identity matrix: components come back untouched, extremes included
        send_word(OP_POINT, 0, 0, WORD_MAX, WORD_MIN, '0, 1'b1);
        send_word(OP_DIRECTION, 0, 0, '1, 32'd1, 32'h1234_5678, 1'b0);
        // reserved code and out-of-range loads must leave no trace
        send_word(OP_RESERVED, 4'd5, WORD_MAX, 32'd7, 32'd8, 32'd9, 1'b1);
        send_word(OP_LOAD, 4'd12, WORD_MAX, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd15, WORD_MIN, 0, 0, 0, 1'b1);
        send_word(OP_POINT, 0, 0, 32'h1234_5678, 32'hedcb_a988, 32'h0001_8000, 1'b0);
        // translation column at the extremes
        send_word(OP_LOAD, 4'd3, WORD_MAX, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd7, WORD_MIN, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd11, UNIT_WORD, 0, 0, 0, 1'b0);
        send_word(OP_POINT, 0, 0, '0, '0, '0, 1'b1);
        // clamp high on x, clamp low on y
        send_word(OP_POINT, 0, 0, WORD_MAX, '0, '0, 1'b0);
        send_word(OP_POINT, 0, 0, '0, WORD_MIN, '0, 1'b0);
        // direction ignores the translation, so no clamp here
        send_word(OP_DIRECTION, 0, 0, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1);
        // tiny coefficient times -1 rounds down to -1
        send_word(OP_LOAD, 4'd4, 32'd1, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd5, '0, 0, 0, 0, 1'b0);
        send_word(OP_DIRECTION, 0, 0, '1, 32'd5, 32'd7, 1'b0);
        // most negative coefficients times most negative components
        send_word(OP_LOAD, 4'd0, WORD_MIN, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd1, WORD_MIN, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 4'd2, WORD_MIN, 0, 0, 0, 1'b0);
        send_word(OP_POINT, 0, 0, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);
        send_word(OP_DIRECTION, 0, 0, '0, '0, '0, 1'b1);

        // random traffic: loads keep reshaping the matrix between vertices
        effective = 0;
        drained   = 1'b0;
        while (effective < RANDOM_ITEMS) begin
            // a long stretch with neither side idling
            if (effective >= QUIET_START && effective < QUIET_END) begin
                busy_pct  = 0;
                stall_pct = 0;
            end else begin
                busy_pct  = 25;
                stall_pct = 25;
            end
            // once, hold off until every pending vertex has come out
            if (effective == DRAIN_AT && !drained) begin
                drained = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (expected_left != 0) @(posedge aclk);
            end
            choice = $urandom_range(0, 99);
            if (choice < 20) begin
                idx = ($urandom_range(0, 9) == 0) ? INDEX_WIDTH'($urandom_range(12, 15))
                                                  : INDEX_WIDTH'($urandom_range(0, 11));
                send_word(OP_LOAD, idx, pick_value(), pick_value(), pick_value(),
                          pick_value(), 1'($urandom_range(0, 1)));
                if (idx < MATRIX_ENTRIES) begin
                    effective++;
                end
            end else if (choice < 23) begin
                send_word(OP_RESERVED, INDEX_WIDTH'($urandom_range(0, 15)), pick_value(),
                          pick_value(), pick_value(), pick_value(), 1'($urandom_range(0, 1)));
            end else if (choice < 62) begin
                send_word(OP_POINT, INDEX_WIDTH'($urandom_range(0, 15)), pick_value(),
                          pick_value(), pick_value(), pick_value(), 1'($urandom_range(0, 1)));
                effective++;
            end else begin
                send_word(OP_DIRECTION, INDEX_WIDTH'($urandom_range(0, 15)), pick_value(),
                          pick_value(), pick_value(), pick_value(), 1'($urandom_range(0, 1)));
                effective++;
            end
        end
        s_valid <= 1'b0;

        // wait for the last vertex, then a little longer for strays
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("affine_vertex_transform_core_test OK");
        end else begin
            $display("affine_vertex_transform_core_test NOT OK");
        end
        $finish;
    end

endmodule
